FILE: design/lscd_pkg.sv
// lscd_pkg: shared types, codes and sizes of the section cache directory
// depends on nothing
package lscd_pkg;
   // section size in bytes (power of two) and number of slots
   localparam int SECTION_SIZE = 4096;
   localparam int SLOT_COUNT   = 32;

   localparam logic [2:0] KIND_LOAD  = 3'd0;
   localparam logic [2:0] KIND_MOVE  = 3'd1;
   localparam logic [2:0] KIND_PATCH = 3'd2;
   localparam logic [2:0] KIND_READ  = 3'd3;
   localparam logic [2:0] KIND_WRITE = 3'd4;
   localparam logic [2:0] KIND_ERROR = 3'd5;

   typedef struct packed {
      logic        mode;
      logic [31:0] file_offset;
      logic [23:0] length;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  slot;
      logic [4:0]  source_slot;
      logic [31:0] section_base;
      logic [11:0] slot_offset;
      logic [23:0] data_offset;
      logic [12:0] byte_count;
      logic [13:0] bytes_available;
      logic        last;
   } rsp_type;
endpackage

FILE: design/lscd_if.sv
// lscd_if: valid/ready channel carrying one payload
// depends on nothing; the payload type is a parameter
interface lscd_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/lru_section_cache_directory_core.sv
// a one-section read may issue a load before its result, a two-section read up to two
// load or move commands; an overlong read gives an error without a scan; a write gives
// one patch per overlapping slot, then write done
// throughput: one request at a time, set by the single slot scan unit that visits one slot
// per cycle unless a write patch waits to be taken; reset: synchronous, bases cleared,
// stamps to slot index, counter to SLOT_COUNT; depends on lscd_pkg and lscd_if
module lru_section_cache_directory_core (
   input logic clock,
   input logic reset,
   lscd_if.sink   req,
   lscd_if.source rsp
);
   import lscd_pkg::*;
   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = SW + 1;
   localparam logic [31:0] S = 32'(SECTION_SIZE);
   localparam logic [SW-1:0] LASTSLOT = SW'(SLOT_COUNT - 1);

   localparam logic [3:0] ST_IDLE = 4'd0, ST_SCAN = 4'd1, ST_DECIDE = 4'd2,
      ST_WSCAN = 4'd4, ST_WAIT = 4'd5, ST_STEP = 4'd6;

   logic [3:0]   state_ff;
   logic [31:0]  base_ff [SLOT_COUNT];
   logic [31:0]  stamp_ff [SLOT_COUNT];
   logic [31:0]  ctr_ff;
   req_type      rq_ff;
   logic [CW-1:0] idx_ff;
   logic         pass_ff;          // 0 first lookup, 1 second lookup
   logic         h1_ff, h2_ff;
   logic [SW-1:0] p1_ff, p2_ff, vic_ff;
   logic [31:0]  low_ff;
   logic [2:0]   step_ff;          // read sequencer step
   logic         ovalid_ff;
   rsp_type      out_ff;
   logic [3:0]   ret_ff;           // state to resume after output taken

   // shared slot compare unit
   logic [SW-1:0] si;
   logic [31:0]  key, d, e, b;
   assign si  = idx_ff[SW-1:0];
   assign b   = base_ff[si];
   assign key = pass_ff ? rq_ff.file_offset + S : rq_ff.file_offset;
   assign d   = key - b;
   assign e   = b - rq_ff.file_offset;
   logic hit;
   assign hit = d < S;

   logic [31:0] ofs, len32, sec_off;
   assign ofs = rq_ff.file_offset;
   assign len32 = {8'd0, rq_ff.length};
   assign sec_off = ofs & (S - 32'd1);
   logic two;
   assign two = ({1'b0, sec_off} + {1'b0, len32}) >= {1'b0, S};

   // slots settled: report the read without a further command
   logic [SW-1:0] p1n;
   logic          decide_done;
   logic [31:0]   run_end;
   assign p1n = p1_ff + 1'b1;
   assign decide_done = two ? (h1_ff && h2_ff && p2_ff == p1n && p1_ff != LASTSLOT) : h1_ff;
   assign run_end = (two ? base_ff[p1n] : base_ff[p1_ff]) + S;

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.payload = out_ff;

   function automatic rsp_type mk(logic [2:0] k, logic [SW-1:0] s, logic [SW-1:0] src,
                                  logic [31:0] bs, logic [11:0] so, logic [23:0] dof,
                                  logic [12:0] cnt, logic [13:0] av, logic l);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.slot = 5'(s);
      r.source_slot = 5'(src);
      r.section_base = bs;
      r.slot_offset = so;
      r.data_offset = dof;
      r.byte_count = cnt;
      r.bytes_available = av;
      r.last = l;
      return r;
   endfunction

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovalid_ff <= 1'b0;
         ctr_ff <= 32'(SLOT_COUNT);
         for (int i = 0; i < SLOT_COUNT; i++) begin
            base_ff[i] <= '0;
            stamp_ff[i] <= 32'(i);
         end
      end else begin
         if (ovalid_ff && rsp.ready) ovalid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  rq_ff <= req.payload;
                  idx_ff <= '0;
                  pass_ff <= 1'b0;
                  h1_ff <= 1'b0;
                  h2_ff <= 1'b0;
                  vic_ff <= '0;
                  low_ff <= stamp_ff[0];
                  step_ff <= '0;
                  if (req.payload.mode) state_ff <= ST_WSCAN;
                  else if ({8'd0, req.payload.length} > S) begin
                     out_ff <= mk(KIND_ERROR, '0, '0, '0, '0, '0, '0, '0, 1'b1);
                     ovalid_ff <= 1'b1;
                     ret_ff <= ST_IDLE;
                     state_ff <= ST_WAIT;
                  end else state_ff <= ST_SCAN;
               end
            end
            // lookup and victim search, one slot per cycle
            ST_SCAN: begin
               if (!pass_ff) begin
                  if (hit && !h1_ff) begin h1_ff <= 1'b1; p1_ff <= si; end
                  if (stamp_ff[si] < low_ff) begin low_ff <= stamp_ff[si]; vic_ff <= si; end
               end else if (hit && !h2_ff) begin
                  h2_ff <= 1'b1; p2_ff <= si;
               end
               if (idx_ff == CW'(SLOT_COUNT - 1)) begin
                  idx_ff <= '0;
                  if (!pass_ff && two) pass_ff <= 1'b1;
                  else state_ff <= ST_DECIDE;
               end else idx_ff <= idx_ff + 1'b1;
            end
            // one command per step
            ST_DECIDE: begin
               if (decide_done) begin
                  state_ff <= ST_STEP;
               end else begin
                  ret_ff <= ST_DECIDE;
                  state_ff <= ST_WAIT;
                  ovalid_ff <= 1'b1;
                  if (!two) begin
                     base_ff[vic_ff] <= ofs - sec_off;
                     out_ff <= mk(KIND_LOAD, vic_ff, '0, ofs - sec_off, '0, '0, '0, '0, 1'b0);
                     p1_ff <= vic_ff; h1_ff <= 1'b1;
                  end else if (h1_ff && !h2_ff) begin
                     if (p1_ff == LASTSLOT) begin
                        base_ff[0] <= base_ff[p1_ff];
                        out_ff <= mk(KIND_MOVE, '0, p1_ff, base_ff[p1_ff], '0, '0, '0, '0,
                                     1'b0);
                        p1_ff <= '0;
                     end else begin
                        base_ff[p1_ff + 1'b1] <= ofs + S - sec_off;
                        out_ff <= mk(KIND_LOAD, p1_ff + 1'b1, '0, ofs + S - sec_off, '0, '0,
                                     '0, '0, 1'b0);
                        p2_ff <= p1_ff + 1'b1; h2_ff <= 1'b1;
                     end
                  end else if (h1_ff) begin
                     if (p1_ff == LASTSLOT) begin
                        if (p2_ff == '0) begin
                           base_ff[1] <= base_ff[0];
                           out_ff <= mk(KIND_MOVE, SW'(1), '0, base_ff[0], '0, '0, '0, '0,
                                        1'b0);
                           p2_ff <= SW'(1);
                        end else begin
                           base_ff[p2_ff - 1'b1] <= base_ff[p1_ff];
                           out_ff <= mk(KIND_MOVE, p2_ff - 1'b1, p1_ff, base_ff[p1_ff], '0,
                                        '0, '0, '0, 1'b0);
                           p1_ff <= p2_ff - 1'b1;
                        end
                     end else begin
                        base_ff[p1_ff + 1'b1] <= base_ff[p2_ff];
                        out_ff <= mk(KIND_MOVE, p1_ff + 1'b1, p2_ff, base_ff[p2_ff], '0, '0,
                                     '0, '0, 1'b0);
                        p2_ff <= p1_ff + 1'b1;
                     end
                  end else if (!h2_ff) begin
                     base_ff[0] <= ofs - sec_off;
                     out_ff <= mk(KIND_LOAD, '0, '0, ofs - sec_off, '0, '0, '0, '0, 1'b0);
                     p1_ff <= '0; h1_ff <= 1'b1;
                  end else if (p2_ff == '0) begin
                     base_ff[1] <= base_ff[0];
                     out_ff <= mk(KIND_MOVE, SW'(1), '0, base_ff[0], '0, '0, '0, '0, 1'b0);
                     p2_ff <= SW'(1);
                  end else begin
                     base_ff[p2_ff - 1'b1] <= ofs - sec_off;
                     out_ff <= mk(KIND_LOAD, p2_ff - 1'b1, '0, ofs - sec_off, '0, '0, '0, '0,
                                  1'b0);
                     p1_ff <= p2_ff - 1'b1; h1_ff <= 1'b1;
                  end
               end
            end
            // stamps and read done
            ST_STEP: begin
               out_ff <= mk(KIND_READ, p1_ff, '0, base_ff[p1_ff], 12'(ofs - base_ff[p1_ff]),
                            '0, '0, 14'(run_end - ofs), 1'b1);
               if (two) begin
                  stamp_ff[p1_ff] <= ctr_ff + 32'd1;
                  stamp_ff[p1n] <= ctr_ff + 32'd2;
                  ctr_ff <= ctr_ff + 32'd2;
               end else begin
                  stamp_ff[p1_ff] <= ctr_ff + 32'd1;
                  ctr_ff <= ctr_ff + 32'd1;
               end
               ovalid_ff <= 1'b1;
               ret_ff <= ST_IDLE;
               state_ff <= ST_WAIT;
            end
            // write patch scan, one slot per cycle while no patch waits to be taken
            ST_WSCAN: begin
               if (idx_ff == CW'(SLOT_COUNT)) begin
                  out_ff <= mk(KIND_WRITE, '0, '0, '0, '0, '0, '0, '0, 1'b1);
                  ovalid_ff <= 1'b1;
                  ret_ff <= ST_IDLE;
                  state_ff <= ST_WAIT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  if (len32 != 0 && hit) begin
                     out_ff <= mk(KIND_PATCH, si, '0, b, 12'(d), '0,
                                  13'((len32 < S - d) ? len32 : S - d), '0, 1'b0);
                     ovalid_ff <= 1'b1;
                     ret_ff <= ST_WSCAN;
                     state_ff <= ST_WAIT;
                  end else if (e != 0 && e < len32) begin
                     out_ff <= mk(KIND_PATCH, si, '0, b, '0, 24'(e),
                                  13'((len32 - e < S) ? len32 - e : S), '0, 1'b0);
                     ovalid_ff <= 1'b1;
                     ret_ff <= ST_WSCAN;
                     state_ff <= ST_WAIT;
                  end
               end
            end
            ST_WAIT: begin
               if (rsp.ready) state_ff <= ret_ff;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready) else $error("ready while busy");
   a_wait_has_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |-> ovalid_ff) else $error("wait without result");
   a_idle_no_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ovalid_ff) else $error("result left over");
endmodule

FILE: dv/tb_top.sv
// tb_top: testbench of the section cache directory, directed table then random requests
// depends on lscd_pkg, lscd_if and lru_section_cache_directory_core
module tb_top;
   import lscd_pkg::*;

   localparam int SEC = 4096;
   localparam int NSLOT = 32;
   localparam int RANDOM_ITEMS = 460;
   localparam int WATCHDOG = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   lscd_if #(.payload_type(req_type)) req_ch (clock);
   lscd_if #(.payload_type(rsp_type)) rsp_ch (clock);

   lru_section_cache_directory_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // predictor state
   logic [31:0] dir_base [NSLOT];
   logic [31:0] dir_stamp [NSLOT];
   logic [31:0] dir_counter;
   rsp_type expected_rsps [$];
   int errors = 0;
   int rsp_seen = 0;
   int idle_cycles = 0;
   bit stim_done = 0;
   bit rsp_hold = 0;
   int reads_seen = 0, writes_seen = 0, moves_seen = 0, errs_seen = 0;

   function automatic rsp_type mk(logic [2:0] k, int s, int src, logic [31:0] b,
                                  logic [31:0] so, logic [31:0] dof, logic [31:0] c,
                                  logic [31:0] av, bit l);
      rsp_type r;
      r.kind = k; r.slot = s[4:0]; r.source_slot = src[4:0]; r.section_base = b;
      r.slot_offset = so[11:0]; r.data_offset = dof[23:0]; r.byte_count = c[12:0];
      r.bytes_available = av[13:0]; r.last = l;
      return r;
   endfunction

   function automatic int find_slot(logic [31:0] ofs);
      for (int i = 0; i < NSLOT; i++)
         if (ofs - dir_base[i] < SEC) return i;
      return -1;
   endfunction

   function automatic int lru_slot();
      int best;
      best = 0;
      for (int i = 1; i < NSLOT; i++)
         if (dir_stamp[i] < dir_stamp[best]) best = i;
      return best;
   endfunction

   function automatic void fill(int s, logic [31:0] ofs);
      dir_base[s] = ofs - (ofs % SEC);
      expected_rsps.push_back(mk(KIND_LOAD, s, 0, dir_base[s], 0, 0, 0, 0, 0));
   endfunction

   function automatic int shift(int src, int dst);
      dir_base[dst] = dir_base[src];
      expected_rsps.push_back(mk(KIND_MOVE, dst, src, dir_base[dst], 0, 0, 0, 0, 0));
      return dst;
   endfunction

   function automatic void touch(int s);
      dir_counter++;
      dir_stamp[s] = dir_counter;
   endfunction

   // expected results of one request
   function automatic void predict_directory(req_type q);
      logic [31:0] ofs, len, avail, d, e, cnt;
      int p1, p2;
      ofs = q.file_offset;
      len = {8'd0, q.length};
      if (q.mode == 1'b0) begin
         if (len > SEC) begin
            expected_rsps.push_back(mk(KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, 1));
            return;
         end
         p1 = find_slot(ofs);
         if ((ofs % SEC) + len < SEC) begin
            if (p1 < 0) begin
               p1 = lru_slot();
               fill(p1, ofs);
            end
            touch(p1);
            avail = dir_base[p1] + SEC - ofs;
         end else begin
            p2 = find_slot(ofs + SEC);
            if (p1 >= 0) begin
               if (p2 < 0) begin
                  if (p1 == NSLOT - 1) p1 = shift(p1, 0);
                  fill(p1 + 1, ofs + SEC);
               end else if (p2 != p1 + 1) begin
                  if (p1 == NSLOT - 1) begin
                     if (p2 == 0) p2 = shift(p2, 1);
                     p1 = shift(p1, p2 - 1);
                  end else begin
                     p2 = shift(p2, p1 + 1);
                  end
               end
            end else if (p2 < 0) begin
               p1 = 0;
               fill(0, ofs);
               fill(1, ofs + SEC);
            end else begin
               if (p2 == 0) p2 = shift(p2, 1);
               p1 = p2 - 1;
               fill(p1, ofs);
            end
            touch(p1);
            touch(p1 + 1);
            avail = dir_base[p1 + 1] + SEC - ofs;
         end
         expected_rsps.push_back(mk(KIND_READ, p1, 0, dir_base[p1], ofs - dir_base[p1],
                                    0, 0, avail, 1));
      end else begin
         for (int i = 0; i < NSLOT; i++) begin
            d = ofs - dir_base[i];
            e = dir_base[i] - ofs;
            if (len > 0 && d < SEC) begin
               cnt = (len < SEC - d) ? len : SEC - d;
               expected_rsps.push_back(mk(KIND_PATCH, i, 0, dir_base[i], d, 0, cnt, 0, 0));
            end else if (e > 0 && e < len) begin
               cnt = (len - e < SEC) ? len - e : SEC;
               expected_rsps.push_back(mk(KIND_PATCH, i, 0, dir_base[i], 0, e, cnt, 0, 0));
            end
         end
         expected_rsps.push_back(mk(KIND_WRITE, 0, 0, 0, 0, 0, 0, 0, 1));
      end
   endfunction

   // directed table; flagged rows carry a typed-in result for the last result of their request
   typedef struct {
      req_type q;
      bit      typed;
      rsp_type r;
   } row_type;
   row_type directed [$];

   function automatic req_type rq(bit m, logic [31:0] o, logic [23:0] l);
      req_type q;
      q.mode = m; q.file_offset = o; q.length = l;
      return q;
   endfunction

   function automatic void add_row(req_type q, bit typed = 0, rsp_type r = '0);
      row_type w;
      w.q = q; w.typed = typed; w.r = r;
      directed.push_back(w);
   endfunction

   // valid stays high from one request to the next when there is no gap
   task automatic send(req_type q);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= q;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (q.mode) writes_seen++; else reads_seen++;
   endtask

   function automatic req_type random_request(int phase);
      req_type q;
      int sel;
      q.mode = $urandom_range(0, 2) == 0;
      sel = $urandom_range(0, 9);
      // mostly offsets near a few sections so hits, moves and overlaps happen
      if (sel < 7)
         q.file_offset = ($urandom_range(0, 40) * SEC + phase * 64 * SEC)
                         + $urandom_range(0, SEC - 1);
      else
         q.file_offset = $urandom();
      sel = $urandom_range(0, 9);
      if (sel < 5) q.length = 24'($urandom_range(0, SEC));
      else if (sel < 7) q.length = 24'($urandom_range(SEC - 16, SEC + 16));
      else if (sel < 9) q.length = 24'($urandom_range(0, 3 * SEC));
      else q.length = 24'($urandom());
      return q;
   endfunction

   // stimulus
   initial begin
      rsp_type pending;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      for (int i = 0; i < NSLOT; i++) begin
         dir_base[i] = 0;
         dir_stamp[i] = i;
      end
      dir_counter = NSLOT;
      // read after reset hits slot 0
      add_row(rq(0, 32'h0000_0010, 24'd16), 1,
              mk(KIND_READ, 0, 0, 0, 32'h10, 0, 0, SEC - 16, 1));
      // overlong read gives an error
      add_row(rq(0, 32'h0000_1000, 24'hFF_FFFF), 1, mk(KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, 1));
      add_row(rq(0, 32'h0000_1000, 24'(SEC + 1)), 1,
              mk(KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, 1));
      // zero-length write gives only write done
      add_row(rq(1, 32'h0000_0000, 24'd0), 1, mk(KIND_WRITE, 0, 0, 0, 0, 0, 0, 0, 1));
      add_row(rq(0, 32'hFFFF_FFFF, 24'd0));
      add_row(rq(0, 32'hFFFF_F000, 24'(SEC)));
      add_row(rq(0, 32'h0000_0FFF, 24'd1));
      add_row(rq(0, 32'h0000_5000, 24'(SEC)));
      add_row(rq(0, 32'h0001_F800, 24'd2048));
      add_row(rq(0, 32'h0000_4800, 24'd4000));
      add_row(rq(1, 32'hFFFF_FFF0, 24'd64));
      add_row(rq(1, 32'h0000_0800, 24'hFF_FFFF));
      add_row(rq(1, 32'hAAAA_5555, 24'h55_AAAA));
      add_row(rq(1, 32'h5555_AAAA, 24'hAA_5555));
      add_row(rq(0, 32'h8000_0000, 24'd1));
      add_row(rq(1, 32'h0000_1000, 24'd1));
      for (int i = 0; i < 6; i++)
         add_row(rq(0, 32'h0100_0000 + i * 3 * SEC + 2048, 24'(SEC)));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         predict_directory(directed[i].q);
         if (directed[i].typed) begin
            pending = expected_rsps[$];
            if (pending !== directed[i].r) begin
               $error("directed row %0d: predictor disagrees with typed result", i);
               errors++;
            end
         end
         send(directed[i].q);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         req_type q;
         q = random_request(n / 60);
         if (n == 200) rsp_hold = 1;
         predict_directory(q);
         send(q);
      end
      req_ch.valid <= 1'b0;
      stim_done = 1;
   end

   // receiver with random stalls and one long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            rsp_hold = 0;
         end else if ($urandom_range(0, 19) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(5, 40)) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // result checking
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         rsp_seen++;
         if (got.kind == KIND_MOVE) moves_seen++;
         if (got.kind == KIND_ERROR) errs_seen++;
         if (expected_rsps.size() == 0) begin
            $error("unexpected result, kind %0d", got.kind);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.kind !== want.kind) begin
               $error("kind: expected %0d got %0d", want.kind, got.kind); errors++;
            end
            if (got.slot !== want.slot) begin
               $error("slot: expected %0d got %0d", want.slot, got.slot); errors++;
            end
            if (got.source_slot !== want.source_slot) begin
               $error("source_slot: expected %0d got %0d", want.source_slot,
                      got.source_slot); errors++;
            end
            if (got.section_base !== want.section_base) begin
               $error("section_base: expected %h got %h", want.section_base,
                      got.section_base); errors++;
            end
            if (got.slot_offset !== want.slot_offset) begin
               $error("slot_offset: expected %h got %h", want.slot_offset,
                      got.slot_offset); errors++;
            end
            if (got.data_offset !== want.data_offset) begin
               $error("data_offset: expected %h got %h", want.data_offset,
                      got.data_offset); errors++;
            end
            if (got.byte_count !== want.byte_count) begin
               $error("byte_count: expected %0d got %0d", want.byte_count,
                      got.byte_count); errors++;
            end
            if (got.bytes_available !== want.bytes_available) begin
               $error("bytes_available: expected %0d got %0d", want.bytes_available,
                      got.bytes_available); errors++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d got %0d", want.last, got.last); errors++;
            end
         end
      end
   end

   // watchdog and end of run
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("timeout, %0d results outstanding", expected_rsps.size());
            $display("FAIL");
            $finish;
         end
         if (stim_done && expected_rsps.size() == 0) begin
            repeat (100) @(posedge clock);
            $display("covered %0d reads, %0d writes, %0d results (%0d moves, %0d errors)",
                     reads_seen, writes_seen, rsp_seen, moves_seen, errs_seen);
            if (errors == 0 && expected_rsps.size() == 0)
               $display("PASS");
            else
               $display("FAIL");
            $finish;
         end
      end
   end
endmodule

FILE: files.f
design/lscd_pkg.sv
design/lscd_if.sv
design/lru_section_cache_directory_core.sv
dv/tb_top.sv
